// ===== src/mdp_vi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_vi_pkg: shared types and constants for mdp value iteration
// item and result layouts, register indexes and shared unit opcodes
// ----------------------------------------------------------------------------
package mdp_vi_pkg;

    // item opcodes
    localparam logic [1:0] ACT_LOAD_ENTRY = 2'd0;
    localparam logic [1:0] ACT_LOAD_VALUE = 2'd1;
    localparam logic [1:0] ACT_RUN        = 2'd2;

    // configuration register indexes
    localparam int          CFG_ADDR_W   = 2;
    localparam logic [1:0]  CFG_DISCOUNT  = 2'd0;
    localparam logic [1:0]  CFG_THRESHOLD = 2'd1;
    localparam logic [1:0]  CFG_ITER_LIMIT = 2'd2;
    localparam int          CFG_DATA_W    = 31;

    localparam logic [16:0] DISCOUNT_RST  = 17'd58982;
    localparam logic [30:0] THRESHOLD_RST = 31'd655;
    localparam logic [15:0] ITER_LIMIT_RST = 16'd1000;
    localparam logic [15:0] DEFAULT_LIMIT = 16'd1000;

    // only the first states are reported
    localparam int MAX_REPORT = 16;

    // shared multiplier opcodes
    localparam logic [1:0] ALU_OP_NONE = 2'd0;
    localparam logic [1:0] ALU_OP_PR   = 2'd1;
    localparam logic [1:0] ALU_OP_PV   = 2'd2;
    localparam logic [1:0] ALU_OP_DISC = 2'd3;

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } alu_ctrl_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         from_state;
        logic [3:0]         to_state;
        logic [1:0]         act_index;
        logic [15:0]        prob;
        logic signed [31:0] reward;
        logic signed [31:0] value_in;
    } item_t;

    typedef struct packed {
        logic [3:0]         state_index;
        logic signed [31:0] value;
        logic [1:0]         best_action;
        logic               converged;
        logic [16:0]        iterations;
        logic               last;
    } result_t;

endpackage

// ===== src/mdp_value_iteration.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_value_iteration: fixed-point markov decision process value iteration
// table loads, expected reward pass, bellman sweeps and per-state results
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_stall / item_data): action 0 writes one
//   transition and reward entry, action 1 writes a starting value, action 2
//   starts a run; loads take one cycle each, code 3 is dropped
//   result channel (result_valid / result_stall / result_data): a run gives
//   one item per reported state in state order, last set on the final one
//   cfg port (cfg_we / cfg_addr / cfg_wdata): discount, threshold, iteration
//   limit, written while the block is idle
// sequencing
//   every multiply-accumulate goes through the one shared multiplier as
//   a table read, a multiply and an accumulate; a run does the reward
//   pass, then bellman sweeps, each followed by a difference pass, then
//   gives one result per reported state
// item_stall is high for the whole run; a stalled result holds its payload
// reset makes unloaded values read as zero and loads the register defaults;
// the policy and the tables hold nothing defined until written
// ----------------------------------------------------------------------------
module mdp_value_iteration
    import mdp_vi_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int NUM_ACTIONS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SW        = $clog2(NUM_STATES);
    localparam int AW        = $clog2(NUM_ACTIONS);
    localparam int TAB_DEPTH = NUM_STATES * NUM_STATES * NUM_ACTIONS;
    localparam int TW        = $clog2(TAB_DEPTH);
    localparam int ER_DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int EW        = $clog2(ER_DEPTH);
    localparam int NREP      = (NUM_STATES < MAX_REPORT) ? NUM_STATES : MAX_REPORT;

    localparam logic [SW-1:0] S_LAST   = SW'(NUM_STATES - 1);
    localparam logic [SW-1:0] REP_LAST = SW'(NREP - 1);
    localparam logic [AW-1:0] A_LAST   = AW'(NUM_ACTIONS - 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PR_RD    = 4'd1;
    localparam logic [3:0] ST_PR_MUL   = 4'd2;
    localparam logic [3:0] ST_PR_ACC   = 4'd3;
    localparam logic [3:0] ST_PR_WR    = 4'd4;
    localparam logic [3:0] ST_SW_START = 4'd5;
    localparam logic [3:0] ST_SW_RD    = 4'd6;
    localparam logic [3:0] ST_SW_MUL   = 4'd7;
    localparam logic [3:0] ST_SW_ACC   = 4'd8;
    localparam logic [3:0] ST_SW_DISC  = 4'd9;
    localparam logic [3:0] ST_SW_Q     = 4'd10;
    localparam logic [3:0] ST_DF_RD    = 4'd11;
    localparam logic [3:0] ST_DF_CMP   = 4'd12;
    localparam logic [3:0] ST_DF_END   = 4'd13;
    localparam logic [3:0] ST_OUT_RD   = 4'd14;
    localparam logic [3:0] ST_OUT      = 4'd15;

    // configuration registers
    logic [16:0] disc_reg;
    logic [30:0] thr_reg;
    logic [15:0] maxit_reg;

    // sequencer
    logic [3:0]         state_reg, state_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [SW-1:0]      s1_reg, s1_next;
    logic [AW-1:0]      a_reg, a_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] best_reg, best_next;
    logic [AW-1:0]      besta_reg, besta_next;
    logic signed [32:0] dmin_reg, dmin_next;
    logic signed [32:0] dmax_reg, dmax_next;
    logic [16:0]        iter_reg, iter_next;
    logic               conv_reg, conv_next;
    logic               bank_reg, bank_next;
    logic               rvalid_reg, rvalid_next;
    result_t            rdata_reg, rdata_next;

    // memories
    logic [15:0]        p_mem   [TAB_DEPTH];
    logic signed [31:0] r_mem   [TAB_DEPTH];
    logic signed [47:0] er_mem  [ER_DEPTH];
    logic signed [31:0] v0_mem  [NUM_STATES];
    logic signed [31:0] v1_mem  [NUM_STATES];
    logic [AW-1:0]      pol_mem [NUM_STATES];
    logic [NUM_STATES-1:0] vld0_reg, vld1_reg;

    logic [15:0]        p_rd_reg;
    logic signed [31:0] r_rd_reg;
    logic signed [47:0] er_rd_reg;
    logic signed [31:0] v0_rd_reg, v1_rd_reg;
    logic               v0_ok_reg, v1_ok_reg;
    logic [AW-1:0]      pol_rd_reg;

    // memory access
    logic               in_take;
    logic               tab_we;
    logic [TW-1:0]      tab_wa, tab_ra;
    logic               er_we;
    logic [EW-1:0]      er_addr;
    logic signed [47:0] er_wd;
    logic               v_we;
    logic [SW-1:0]      v_wa;
    logic signed [31:0] v_wd;
    logic               pol_we;
    logic [SW-1:0]      v0_ra, v1_ra;
    logic               in_sweep;

    // datapath
    alu_ctrl_t          alu_ctrl;
    logic signed [66:0] prod;
    logic signed [31:0] v0_val, v1_val, v_now, v_prev;
    logic signed [51:0] q_sum;
    logic signed [31:0] q_sat;
    logic               q_take;
    logic signed [31:0] best_fin;
    logic [AW-1:0]      besta_fin;
    logic signed [32:0] diff;
    logic signed [33:0] span;
    logic [15:0]        limit;
    logic               in_range;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        if (x[48] != x[47])
        begin
            return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return x[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        if (x[51:31] != {21{x[31]}})
        begin
            return x[51] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return x[31:0];
    endfunction

    mdp_vi_alu u_alu
    (
        .clk      (clk),
        .ctrl     (alu_ctrl),
        .p_data   (p_rd_reg),
        .r_data   (r_rd_reg),
        .v_data   (v_prev),
        .acc      (acc_reg),
        .discount (disc_reg),
        .prod     (prod)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_reg  <= DISCOUNT_RST;
            thr_reg   <= THRESHOLD_RST;
            maxit_reg <= ITER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DISCOUNT:   disc_reg  <= cfg_wdata[16:0];
                CFG_THRESHOLD:  thr_reg   <= cfg_wdata[30:0];
                CFG_ITER_LIMIT: maxit_reg <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign in_take      = item_valid && !item_stall;
    assign result_valid = rvalid_reg;
    assign result_data  = rdata_reg;

    assign in_range = (int'(item_data.from_state) < NUM_STATES)
                   && (int'(item_data.to_state) < NUM_STATES)
                   && (int'(item_data.act_index) < NUM_ACTIONS);

    assign tab_we = in_take && (item_data.action == ACT_LOAD_ENTRY) && in_range;
    assign tab_wa = TW'((int'(item_data.from_state) * NUM_STATES
                       + int'(item_data.to_state)) * NUM_ACTIONS
                       + int'(item_data.act_index));
    assign tab_ra = TW'((int'(s_reg) * NUM_STATES + int'(s1_reg)) * NUM_ACTIONS
                       + int'(a_reg));
    assign er_addr = EW'(int'(s_reg) * NUM_ACTIONS + int'(a_reg));
    assign er_we   = (state_reg == ST_PR_WR);
    assign er_wd   = sat48(acc_reg[63:15]);

    // value banks: bank_reg holds the current values, the other the previous
    assign in_sweep = (state_reg == ST_SW_RD);
    assign v0_ra    = (in_sweep && bank_reg) ? s1_reg : s_reg;
    assign v1_ra    = (in_sweep && !bank_reg) ? s1_reg : s_reg;
    assign v0_val   = v0_ok_reg ? v0_rd_reg : 32'sd0;
    assign v1_val   = v1_ok_reg ? v1_rd_reg : 32'sd0;
    assign v_now    = bank_reg ? v1_val : v0_val;
    assign v_prev   = bank_reg ? v0_val : v1_val;

    // q = floor(floor(sum/2^15) * discount / 2^16) + expected reward, saturated
    assign q_sum     = 52'($signed(prod[66:16])) + 52'(er_rd_reg);
    assign q_sat     = sat32(q_sum);
    assign q_take    = (a_reg == '0) || (q_sat > best_reg);
    assign best_fin  = q_take ? q_sat : best_reg;
    assign besta_fin = q_take ? a_reg : besta_reg;

    assign diff  = 33'(v_now) - 33'(v_prev);
    assign span  = 34'(dmax_reg) - 34'(dmin_reg);
    assign limit = (maxit_reg == 16'd0) ? DEFAULT_LIMIT : maxit_reg;

    always_comb
    begin
        v_we   = 1'b0;
        v_wa   = s_reg;
        v_wd   = best_fin;
        pol_we = 1'b0;
        if (in_take && (item_data.action == ACT_LOAD_VALUE)
            && (int'(item_data.from_state) < NUM_STATES))
        begin
            v_we = 1'b1;
            v_wa = SW'(item_data.from_state);
            v_wd = item_data.value_in;
        end
        else if ((state_reg == ST_SW_Q) && (a_reg == A_LAST))
        begin
            v_we   = 1'b1;
            pol_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            p_mem[tab_wa] <= item_data.prob;
            r_mem[tab_wa] <= item_data.reward;
        end
        p_rd_reg <= p_mem[tab_ra];
        r_rd_reg <= r_mem[tab_ra];
    end

    always_ff @(posedge clk)
    begin
        if (er_we)
        begin
            er_mem[er_addr] <= er_wd;
        end
        er_rd_reg <= er_mem[er_addr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we && !bank_reg)
        begin
            v0_mem[v_wa] <= v_wd;
        end
        if (v_we && bank_reg)
        begin
            v1_mem[v_wa] <= v_wd;
        end
        v0_rd_reg <= v0_mem[v0_ra];
        v1_rd_reg <= v1_mem[v1_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pol_we)
        begin
            pol_mem[s_reg] <= besta_fin;
        end
        pol_rd_reg <= pol_mem[s_reg];
    end

    // written marks so that unloaded values read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg  <= '0;
            vld1_reg  <= '0;
            v0_ok_reg <= 1'b0;
            v1_ok_reg <= 1'b0;
        end
        else
        begin
            if (v_we && !bank_reg)
            begin
                vld0_reg[v_wa] <= 1'b1;
            end
            if (v_we && bank_reg)
            begin
                vld1_reg[v_wa] <= 1'b1;
            end
            v0_ok_reg <= vld0_reg[v0_ra];
            v1_ok_reg <= vld1_reg[v1_ra];
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        s1_next     = s1_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        besta_next  = besta_reg;
        dmin_next   = dmin_reg;
        dmax_next   = dmax_reg;
        iter_next   = iter_reg;
        conv_next   = conv_reg;
        bank_next   = bank_reg;
        rvalid_next = rvalid_reg;
        rdata_next  = rdata_reg;
        alu_ctrl    = '{en: 1'b0, op: ALU_OP_NONE};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (item_data.action == ACT_RUN))
                begin
                    s_next     = '0;
                    s1_next    = '0;
                    a_next     = '0;
                    acc_next   = '0;
                    iter_next  = '0;
                    state_next = ST_PR_RD;
                end
            end
            ST_PR_RD:
            begin
                state_next = ST_PR_MUL;
            end
            ST_PR_MUL:
            begin
                alu_ctrl   = '{en: 1'b1, op: ALU_OP_PR};
                state_next = ST_PR_ACC;
            end
            ST_PR_ACC:
            begin
                acc_next = acc_reg + prod[63:0];
                if (s1_reg == S_LAST)
                begin
                    state_next = ST_PR_WR;
                end
                else
                begin
                    s1_next    = s1_reg + 1'b1;
                    state_next = ST_PR_RD;
                end
            end
            ST_PR_WR:
            begin
                acc_next = '0;
                s1_next  = '0;
                if (a_reg == A_LAST)
                begin
                    a_next = '0;
                    if (s_reg == S_LAST)
                    begin
                        state_next = ST_SW_START;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_PR_RD;
                    end
                end
                else
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = ST_PR_RD;
                end
            end
            ST_SW_START:
            begin
                // swapping banks turns the current values into the previous ones
                bank_next  = !bank_reg;
                iter_next  = iter_reg + 1'b1;
                s_next     = '0;
                s1_next    = '0;
                a_next     = '0;
                acc_next   = '0;
                state_next = ST_SW_RD;
            end
            ST_SW_RD:
            begin
                state_next = ST_SW_MUL;
            end
            ST_SW_MUL:
            begin
                alu_ctrl   = '{en: 1'b1, op: ALU_OP_PV};
                state_next = ST_SW_ACC;
            end
            ST_SW_ACC:
            begin
                acc_next = acc_reg + prod[63:0];
                if (s1_reg == S_LAST)
                begin
                    state_next = ST_SW_DISC;
                end
                else
                begin
                    s1_next    = s1_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_SW_DISC:
            begin
                alu_ctrl   = '{en: 1'b1, op: ALU_OP_DISC};
                state_next = ST_SW_Q;
            end
            ST_SW_Q:
            begin
                best_next  = best_fin;
                besta_next = besta_fin;
                acc_next   = '0;
                s1_next    = '0;
                if (a_reg == A_LAST)
                begin
                    a_next = '0;
                    if (s_reg == S_LAST)
                    begin
                        s_next     = '0;
                        state_next = ST_DF_RD;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_SW_RD;
                    end
                end
                else
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_DF_RD:
            begin
                state_next = ST_DF_CMP;
            end
            ST_DF_CMP:
            begin
                if ((s_reg == '0) || (diff < dmin_reg))
                begin
                    dmin_next = diff;
                end
                if ((s_reg == '0) || (diff > dmax_reg))
                begin
                    dmax_next = diff;
                end
                if (s_reg == S_LAST)
                begin
                    state_next = ST_DF_END;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_DF_RD;
                end
            end
            ST_DF_END:
            begin
                s_next = '0;
                if (span < $signed({3'b000, thr_reg}))
                begin
                    conv_next  = 1'b1;
                    state_next = ST_OUT_RD;
                end
                else if (iter_reg > {1'b0, limit})
                begin
                    conv_next  = 1'b0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_SW_START;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rvalid_reg)
                begin
                    rvalid_next = 1'b1;
                    rdata_next  = '{state_index: 4'(s_reg),
                                    value:       v_now,
                                    best_action: 2'(pol_rd_reg),
                                    converged:   conv_reg,
                                    iterations:  iter_reg,
                                    last:        (s_reg == REP_LAST)};
                end
                else if (!result_stall)
                begin
                    rvalid_next = 1'b0;
                    if (s_reg == REP_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s_reg      <= '0;
            s1_reg     <= '0;
            a_reg      <= '0;
            iter_reg   <= '0;
            conv_reg   <= 1'b0;
            bank_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s_reg      <= s_next;
            s1_reg     <= s1_next;
            a_reg      <= a_next;
            iter_reg   <= iter_next;
            conv_reg   <= conv_next;
            bank_reg   <= bank_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        besta_reg <= besta_next;
        dmin_reg  <= dmin_next;
        dmax_reg  <= dmax_next;
        rdata_reg <= rdata_next;
    end

endmodule

// ===== src/mdp_vi_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_vi_alu: shared multiplier
// one registered 49 x 18 signed multiply, operands picked by opcode
// ----------------------------------------------------------------------------
module mdp_vi_alu
    import mdp_vi_pkg::*;
(
    input  logic                clk,
    input  alu_ctrl_t           ctrl,
    input  logic [15:0]         p_data,
    input  logic signed [31:0]  r_data,
    input  logic signed [31:0]  v_data,
    input  logic signed [63:0]  acc,
    input  logic [16:0]         discount,
    output logic signed [66:0]  prod
);

    logic signed [48:0] op_a;
    logic signed [17:0] op_b;
    logic signed [66:0] prod_reg;

    always_comb
    begin
        case (ctrl.op)
            ALU_OP_PR:
            begin
                op_a = {{17{r_data[31]}}, r_data};
                op_b = {2'b00, p_data};
            end
            ALU_OP_PV:
            begin
                op_a = {{17{v_data[31]}}, v_data};
                op_b = {2'b00, p_data};
            end
            ALU_OP_DISC:
            begin
                // floor of acc / 2^15 times discount
                op_a = acc[63:15];
                op_b = {1'b0, discount};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= 67'(op_a) * 67'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== tb/sv/mdp_value_iteration_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_value_iteration_test: self-checking bench for mdp value iteration
// fills the tables, drives directed and random load and run items through a
// queue-fed driver, predicts every per-state result and checks it in order
// ----------------------------------------------------------------------------
module mdp_value_iteration_test;
    import mdp_vi_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item_data;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mdp_value_iteration dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // predictor state: tables, values, policy and register copies
    logic [15:0]        prob_tab [1024];
    logic signed [31:0] rew_tab  [1024];
    logic signed [31:0] val_now  [16];
    logic [1:0]         policy   [16];
    logic [16:0]        disc_reg;
    logic [30:0]        thr_reg;
    logic [15:0]        limit_reg;

    item_t   pending_items [$];
    result_t state_results [$];
    int      mismatches;
    int      idle_pct;
    int      stall_pct;
    bit      took;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // global time limit, far beyond the slowest correct run
    initial
    begin
        #300ms;
        $display("status: fail");
        $finish;
    end

    // work out the results caused by one accepted item
    function automatic void bellman_predict(item_t it);
        logic [9:0]  idx;
        longint      acc;
        longint      q;
        longint      best;
        longint      d;
        longint      dmin;
        longint      dmax;
        longint      pr [16][4];
        logic signed [31:0] prev [16];
        int          lim;
        int          iters;
        bit          conv;
        bit          done;
        result_t     r;
        idx = {it.from_state, it.to_state, it.act_index};
        if (it.action == ACT_LOAD_ENTRY)
        begin
            prob_tab[idx] = it.prob;
            rew_tab[idx]  = it.reward;
        end
        else if (it.action == ACT_LOAD_VALUE)
            val_now[it.from_state] = it.value_in;
        else if (it.action == ACT_RUN)
        begin
            // expected reward per state and action, saturated to 48 bits
            for (int s = 0; s < 16; s++)
                for (int a = 0; a < 4; a++)
                begin
                    acc = 0;
                    for (int s1 = 0; s1 < 16; s1++)
                    begin
                        idx = {s[3:0], s1[3:0], a[1:0]};
                        acc += longint'(prob_tab[idx]) * longint'(rew_tab[idx]);
                    end
                    acc = acc >>> 15;
                    if (acc < -(64'sd1 <<< 47))
                        acc = -(64'sd1 <<< 47);
                    else if (acc > (64'sd1 <<< 47) - 1)
                        acc = (64'sd1 <<< 47) - 1;
                    pr[s][a] = acc;
                end
            lim = (limit_reg == 0) ? int'(DEFAULT_LIMIT) : int'(limit_reg);
            iters = 0;
            conv = 1'b0;
            done = 1'b0;
            while (!done)
            begin
                iters++;
                prev = val_now;
                for (int s = 0; s < 16; s++)
                begin
                    best = 0;
                    for (int a = 0; a < 4; a++)
                    begin
                        acc = 0;
                        for (int s1 = 0; s1 < 16; s1++)
                        begin
                            idx = {s[3:0], s1[3:0], a[1:0]};
                            acc += longint'(prob_tab[idx]) * longint'(prev[s1]);
                        end
                        q = ((acc >>> 15) * longint'(disc_reg)) >>> 16;
                        q = q + pr[s][a];
                        if (q < -64'sd2147483648)
                            q = -64'sd2147483648;
                        else if (q > 64'sd2147483647)
                            q = 64'sd2147483647;
                        // ties keep the lowest action
                        if (a == 0 || q > best)
                        begin
                            best = q;
                            policy[s] = a[1:0];
                        end
                    end
                    val_now[s] = best[31:0];
                end
                dmin = 0;
                dmax = 0;
                for (int s = 0; s < 16; s++)
                begin
                    d = longint'(val_now[s]) - longint'(prev[s]);
                    if (s == 0 || d < dmin)
                        dmin = d;
                    if (s == 0 || d > dmax)
                        dmax = d;
                end
                if (dmax - dmin < longint'(thr_reg))
                begin
                    conv = 1'b1;
                    done = 1'b1;
                end
                else if (iters > lim)
                    done = 1'b1;
            end
            for (int s = 0; s < 16; s++)
            begin
                r.state_index = s[3:0];
                r.value       = val_now[s];
                r.best_action = policy[s];
                r.converged   = conv;
                r.iterations  = iters[16:0];
                r.last        = (s == 15);
                state_results.push_back(r);
            end
        end
    endfunction

    // item driver: accept at the rising edge, present at the falling edge
    always @(posedge clk)
    begin
        took = item_valid && !item_stall;
        if (took)
        begin
            bellman_predict(pending_items[0]);
            void'(pending_items.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && !took)
            item_valid <= 1'b1;
        else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            item_valid <= 1'b1;
            item_data  <= pending_items[0];
        end
        else
            item_valid <= 1'b0;
    end

    // result monitor and random receiver stall
    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && !result_stall)
        begin
            if (state_results.size() == 0)
            begin
                $error("result item with nothing expected, state %0d",
                       result_data.state_index);
                mismatches++;
            end
            else
            begin
                want = state_results.pop_front();
                if (result_data.state_index !== want.state_index)
                begin
                    $error("state_index exp %0d got %0d", want.state_index,
                           result_data.state_index);
                    mismatches++;
                end
                if (result_data.value !== want.value)
                begin
                    $error("value exp %0d got %0d", want.value, result_data.value);
                    mismatches++;
                end
                if (result_data.best_action !== want.best_action)
                begin
                    $error("best_action exp %0d got %0d", want.best_action,
                           result_data.best_action);
                    mismatches++;
                end
                if (result_data.converged !== want.converged)
                begin
                    $error("converged exp %0d got %0d", want.converged,
                           result_data.converged);
                    mismatches++;
                end
                if (result_data.iterations !== want.iterations)
                begin
                    $error("iterations exp %0d got %0d", want.iterations,
                           result_data.iterations);
                    mismatches++;
                end
                if (result_data.last !== want.last)
                begin
                    $error("last exp %0d got %0d", want.last, result_data.last);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // hold the sender until every queued item is in and every result is out,
    // then give the block time to settle before registers change
    task automatic drain();
        while (pending_items.size() > 0 || item_valid || state_results.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // write all three registers while idle
    task automatic set_config(logic [16:0] disc, logic [30:0] thr, logic [15:0] lim);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DISCOUNT;
        cfg_wdata <= CFG_DATA_W'(disc);
        @(negedge clk);
        cfg_addr  <= CFG_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge clk);
        cfg_addr  <= CFG_ITER_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(negedge clk);
        cfg_we    <= 1'b0;
        disc_reg  = disc;
        thr_reg   = thr;
        limit_reg = lim;
    endtask

    function automatic item_t make_item(logic [1:0] op, int f, int t, int a,
                                        int p, int r, int v);
        item_t it;
        it.action     = op;
        it.from_state = f[3:0];
        it.to_state   = t[3:0];
        it.act_index  = a[1:0];
        it.prob       = p[15:0];
        it.reward     = r;
        it.value_in   = v;
        return it;
    endfunction

    // one random item: mostly table writes with modest weights, some value
    // loads, a few runs and the odd unused code
    function automatic item_t random_item();
        int pick;
        int p;
        int r;
        int v;
        logic [1:0] op;
        pick = $urandom_range(99);
        p = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                     : int'($urandom_range(2048));
        r = ($urandom_range(9) == 0) ? int'($urandom)
                                     : int'($urandom_range(2097152)) - 1048576;
        v = ($urandom_range(4) == 0) ? int'($urandom)
                                     : int'($urandom_range(8388608)) - 4194304;
        if (pick < 72)
            op = ACT_LOAD_ENTRY;
        else if (pick < 88)
            op = ACT_LOAD_VALUE;
        else if (pick < 97)
            op = ACT_RUN;
        else
            op = 2'd3;
        return make_item(op, $urandom_range(15), $urandom_range(15),
                         $urandom_range(3), p, r, v);
    endfunction

    initial
    begin
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 66, 0, 24};
        stall_set = '{0, 0, 66, 24};
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_data    = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        mismatches   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        took         = 1'b0;
        disc_reg     = DISCOUNT_RST;
        thr_reg      = THRESHOLD_RST;
        limit_reg    = ITER_LIMIT_RST;
        for (int s = 0; s < 16; s++)
        begin
            val_now[s] = 0;
            policy[s]  = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every table entry so no run reads an unwritten one
        for (int i = 0; i < 1024; i++)
            pending_items.push_back(make_item(ACT_LOAD_ENTRY, i >> 6, (i >> 2) & 15,
                i & 3, $urandom_range(2048), int'($urandom_range(2097152)) - 1048576, 0));
        // a run with full discount and the largest threshold, so it stays short
        drain();
        set_config(17'd65536, 31'h7fffffff, 16'd65535);
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0, 0));
        drain();
        // limit of zero falls back to the default count
        set_config(17'd58982, 31'h7fffffff, 16'd0);
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0, 0));
        drain();

        // field extremes, unused code, threshold zero never converging
        set_config(17'd1, 31'd0, 16'd1);
        pending_items.push_back(make_item(ACT_LOAD_VALUE, 0, 0, 0, 0, 0, 32'sh80000000));
        pending_items.push_back(make_item(ACT_LOAD_VALUE, 15, 0, 0, 0, 0, 32'sh7fffffff));
        pending_items.push_back(make_item(ACT_LOAD_ENTRY, 0, 15, 3, 65535,
                                          32'sh80000000, 0));
        pending_items.push_back(make_item(ACT_LOAD_ENTRY, 15, 0, 0, 32768,
                                          32'sh7fffffff, 0));
        pending_items.push_back(make_item(ACT_LOAD_ENTRY, 7, 7, 1, 0, -1, 0));
        pending_items.push_back(make_item(2'd3, 15, 15, 3, 65535, -1, -1));
        pending_items.push_back(make_item(ACT_RUN, 15, 15, 3, 65535, -1, -1));
        pending_items.push_back(make_item(ACT_LOAD_ENTRY, 0, 15, 3, 1024, 65536, 0));
        pending_items.push_back(make_item(ACT_LOAD_ENTRY, 15, 0, 0, 1024, -65536, 0));
        drain();
        set_config(17'd65536, 31'd1, 16'd2);
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0, 0));
        drain();

        // random phases across the idling mixes, new registers each time
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct  = idle_set[ph % 4];
            stall_pct = stall_set[ph % 4];
            set_config(17'($urandom_range(65536, 1)),
                       ($urandom_range(3) == 0) ? 31'($urandom)
                                                : 31'($urandom_range(200000, 1)),
                       16'($urandom_range(3, 1)));
            for (int n = 0; n < 25; n++)
                pending_items.push_back(random_item());
            pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0, 0));
            drain();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
